### rtl/gbcl_pkg.sv
package gbcl_pkg;

  // Field widths
  localparam int unsigned RawW   = 16;
  localparam int unsigned RateW  = 23;
  localparam int unsigned AlphaW = 17;

  // Calibration sum holds up to 4096 samples of 16-bit counts
  localparam int unsigned SumW = 28;

  // Filter state: gyro counts with 16 fraction bits
  localparam int unsigned FiltW = 34;

  // Filter weight in unsigned Q1.16
  localparam logic [AlphaW-1:0] AlphaOne   = 17'd65536;
  localparam logic [AlphaW-1:0] AlphaReset = 17'd52429;

  // round(2^32 * pi / 180 / 65.5)
  localparam int unsigned RateKW = 22;
  localparam logic signed [RateKW-1:0] RateK = 22'sd1144448;

  // Default number of calibration items after reset
  localparam int unsigned CalSamplesDefault = 200;

  // Per-lane control strobes from the sequencer
  typedef struct packed {
    logic cal_add;
    logic div_load;
    logic bias_load;
    logic capture;
    logic mul1;
    logic acc;
    logic mul2;
  } lane_ctrl_t;

endpackage

### rtl/gbcl_lane.sv
module gbcl_lane
  import gbcl_pkg::*;
#(
  parameter int unsigned CAL_SAMPLES = CalSamplesDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctrl_t              ctrl_i,
  input  logic [AlphaW-1:0]       alpha_i,
  input  logic signed [RawW-1:0]  gyro_i,
  output logic signed [RateW-1:0] rate_o
);

  // Reciprocal of CAL_SAMPLES, exact for every sum magnitude below 2^SumW
  localparam int unsigned RecipSh = SumW + $clog2(CAL_SAMPLES);
  localparam int unsigned RecipW  = SumW + 1;
  localparam logic [RecipW-1:0] Recip = RecipW'(((64'd1 << RecipSh) + 64'(CAL_SAMPLES)
                                                 - 64'd1) / 64'(CAL_SAMPLES));
  localparam int unsigned QProdW = SumW + RecipW;
  localparam int unsigned DeltaW = FiltW + 1;
  localparam int unsigned Prod1W = DeltaW + AlphaW + 1;
  localparam int unsigned StepW = Prod1W - 16;
  localparam int unsigned Prod2W = FiltW + RateKW;

  logic signed [SumW-1:0]   sum_q;
  logic signed [RawW-1:0]   bias_q;
  logic signed [RawW-1:0]   g_q;
  logic signed [FiltW-1:0]  filt_q;
  logic signed [Prod1W-1:0] prod1_q;
  logic signed [Prod2W-1:0] prod2_q;
  logic [QProdW-1:0]        qprod_q;
  logic                     neg_q;

  logic [SumW-1:0]          sum_mag;
  logic signed [RawW:0]     diff;
  logic signed [DeltaW-1:0] delta;
  logic signed [AlphaW:0]   alpha_s;
  logic signed [Prod1W-1:0] prod1_adj;
  logic signed [StepW-1:0]  step;
  logic signed [Prod2W-1:0] prod2_adj;

  // Magnitude of the calibration sum for the unsigned quotient
  assign sum_mag = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  // Filter input and error against the state
  assign diff    = (RawW + 1)'(g_q) - (RawW + 1)'(bias_q);
  assign delta   = DeltaW'(signed'({diff, 16'h0000})) - DeltaW'(filt_q);
  assign alpha_s = {1'b0, alpha_i};

  // Divide by 2^16 toward zero
  assign prod1_adj = prod1_q + (prod1_q[Prod1W-1] ? Prod1W'(65535) : Prod1W'(0));
  assign step      = StepW'(prod1_adj >>> 16);

  // Scale to rad/s, divide by 2^32 toward zero
  assign prod2_adj = prod2_q + (prod2_q[Prod2W-1] ? Prod2W'(64'hFFFF_FFFF) : Prod2W'(0));
  assign rate_o    = prod2_adj[32 +: RateW];

  // Hold calibration, bias and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      bias_q <= '0;
      filt_q <= '0;
    end else begin
      if (ctrl_i.cal_add) begin
        sum_q <= sum_q + SumW'(gyro_i);
      end
      if (ctrl_i.bias_load) begin
        bias_q <= neg_q ? RawW'(-qprod_q[RecipSh +: RawW])
                        : signed'(qprod_q[RecipSh +: RawW]);
      end
      if (ctrl_i.acc) begin
        filt_q <= filt_q + FiltW'(step);
      end
    end
  end

  // Quotient and datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      qprod_q <= QProdW'(sum_mag) * QProdW'(Recip);
      neg_q   <= sum_q[SumW-1];
    end
    if (ctrl_i.capture) begin
      g_q <= gyro_i;
    end
    if (ctrl_i.mul1) begin
      prod1_q <= Prod1W'(alpha_s) * Prod1W'(delta);
    end
    if (ctrl_i.mul2) begin
      prod2_q <= Prod2W'(filt_q) * Prod2W'(RateK);
    end
  end

endmodule

### rtl/gyro_bias_calibrate_lowpass.sv
// Gyro bias removal and low-pass filter for a six-axis IMU sample stream. The first
// CAL_SAMPLES items after reset calibrate: their gyro counts are summed per axis and
// each gives no result. After the last one each lane forms its bias by a reciprocal
// multiplication (multiply, bias write), during which no item is accepted. Every later
// item gives one result and occupies the block through capture, weight multiply, filter
// accumulate, rad/s scale multiply and output load. The three gyro axes run in lanes
// side by side; the output register lets a result wait while the next item is accepted.
// filter_alpha is Q1.16, values above 65536 act as 65536.
module gyro_bias_calibrate_lowpass
  import gbcl_pkg::*;
#(
  parameter int unsigned CAL_SAMPLES = CalSamplesDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [AlphaW-1:0]       filter_alpha_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [RawW-1:0]  accel_x_raw_i,
  input  logic signed [RawW-1:0]  accel_y_raw_i,
  input  logic signed [RawW-1:0]  accel_z_raw_i,
  input  logic signed [RawW-1:0]  gyro_x_raw_i,
  input  logic signed [RawW-1:0]  gyro_y_raw_i,
  input  logic signed [RawW-1:0]  gyro_z_raw_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [RateW-1:0] rate_x_rad_o,
  output logic signed [RateW-1:0] rate_y_rad_o,
  output logic signed [RateW-1:0] rate_z_rad_o,
  output logic signed [RawW-1:0]  accel_x_g_o,
  output logic signed [RawW-1:0]  accel_y_g_o,
  output logic signed [RawW-1:0]  accel_z_g_o
);

  localparam int unsigned CntW = $clog2(CAL_SAMPLES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DLOAD = 3'd1;
  localparam logic [2:0] S_BIAS  = 3'd3;
  localparam logic [2:0] S_MUL1  = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;
  localparam logic [2:0] S_MUL2  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [CntW-1:0]     cal_cnt_q;
  logic                cal_done_q;
  logic [AlphaW-1:0]   alpha_q;
  logic [AlphaW-1:0]   alpha_eff;
  logic signed [RawW-1:0] ax_q, ay_q, az_q;
  logic                out_valid_q;
  logic                in_acc;
  logic                out_load;
  lane_ctrl_t          ctrl;
  logic signed [RateW-1:0] rate_x, rate_y, rate_z;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // Saturate the filter weight at one
  assign alpha_eff = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;

  // Sequence the lanes
  always_comb begin
    state_d        = state_q;
    ctrl           = '0;
    ctrl.div_load  = (state_q == S_DLOAD);
    ctrl.bias_load = (state_q == S_BIAS);
    ctrl.mul1      = (state_q == S_MUL1);
    ctrl.acc       = (state_q == S_ACC);
    ctrl.mul2      = (state_q == S_MUL2);
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!cal_done_q) begin
            ctrl.cal_add = 1'b1;
            if (cal_cnt_q == CntW'(CAL_SAMPLES - 1)) begin
              state_d = S_DLOAD;
            end
          end else begin
            ctrl.capture = 1'b1;
            state_d      = S_MUL1;
          end
        end
      end
      S_DLOAD: state_d = S_BIAS;
      S_BIAS:  state_d = S_IDLE;
      S_MUL1:  state_d = S_ACC;
      S_ACC:   state_d = S_MUL2;
      S_MUL2:  state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cal_cnt_q   <= '0;
      cal_done_q  <= 1'b0;
      alpha_q     <= AlphaReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        alpha_q <= filter_alpha_i;
      end
      if (ctrl.cal_add) begin
        cal_cnt_q <= cal_cnt_q + CntW'(1);
      end
      if (ctrl.bias_load) begin
        cal_done_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the accelerometer counts while the lanes work
  always_ff @(posedge clk_i) begin
    if (ctrl.capture) begin
      ax_q <= accel_x_raw_i;
      ay_q <= accel_y_raw_i;
      az_q <= accel_z_raw_i;
    end
  end

  gbcl_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .alpha_i(alpha_eff),
    .gyro_i (gyro_x_raw_i),
    .rate_o (rate_x)
  );

  gbcl_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .alpha_i(alpha_eff),
    .gyro_i (gyro_y_raw_i),
    .rate_o (rate_y)
  );

  gbcl_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .alpha_i(alpha_eff),
    .gyro_i (gyro_z_raw_i),
    .rate_o (rate_z)
  );

  // Merge lane rates and accel counts into the output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rate_x_rad_o <= rate_x;
      rate_y_rad_o <= rate_y;
      rate_z_rad_o <= rate_z;
      accel_x_g_o  <= ax_q;
      accel_y_g_o  <= ay_q;
      accel_z_g_o  <= az_q;
    end
  end

  // A result appears only from the output stage
  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output stage");

  // No result while calibrating
  a_no_result_in_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cal_done_q)
    else $error("result during calibration");

  // Calibration, once done, stays done
  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_done_q |=> cal_done_q)
    else $error("calibration flag cleared");

  // No item taken while the bias is formed
  a_busy_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DLOAD || state_q == S_BIAS) |-> !in_ready_o)
    else $error("item accepted during bias divide");

endmodule
